>>> hw/rtl/sct_pkg.sv
// ----------------------------------------------------------------------------
// Server clock tracker package
// Shared types, register indexes and time comparison helpers for the tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package sct_pkg;

   localparam int TIME_BITS = 32;
   localparam int MS_BITS   = 31;
   localparam int THR_BITS  = 16;
   localparam int CSR_BITS  = 16;
   localparam int IDX_BITS  = 3;

   localparam logic [7:0] NUDGE_MAX = 8'd30;

   typedef logic [TIME_BITS-1:0] time_type;
   typedef logic [MS_BITS-1:0]   ms_type;

   localparam logic [IDX_BITS-1:0] CSR_RESET_THR  = 3'd0;
   localparam logic [IDX_BITS-1:0] CSR_FAST_THR   = 3'd1;
   localparam logic [IDX_BITS-1:0] CSR_TIME_NUDGE = 3'd2;
   localparam logic [IDX_BITS-1:0] CSR_FINE_DRIFT = 3'd3;
   localparam logic [IDX_BITS-1:0] CSR_EDGE_MARGIN = 3'd4;

   typedef enum logic [2:0] {
      ADJ_NONE,
      ADJ_RESET,
      ADJ_FAST,
      ADJ_FWD,
      ADJ_BACK
   } adjust_type;

   typedef struct packed {
      logic [THR_BITS-1:0] reset_threshold;
      logic [THR_BITS-1:0] fast_threshold;
      logic signed [7:0]   time_nudge;
      logic                fine_drift_enable;
      logic [7:0]          edge_margin;
   } cfg_type;

   typedef struct packed {
      ms_type local_time;
      ms_type snap_time;
      logic   new_snapshot;
      logic   snap_inactive;
      logic   paused;
   } item_type;

   typedef struct packed {
      logic     active;
      logic     extrapolated;
      logic     pending;
      time_type offset;
      time_type last_view;
      time_type last_frame_snap;
      time_type view_reg;
   } state_type;

   typedef struct packed {
      ms_type     view_time;
      logic       is_active;
      adjust_type adjust_mode;
      logic       resynced;
   } result_type;

   // Two's complement ordering within the time width.
   function automatic logic time_less(input time_type a, input time_type b);
      return $signed(a) < $signed(b);
   endfunction

   function automatic time_type time_abs(input time_type a);
      return a[TIME_BITS-1] ? time_type'(-a) : a;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/server_clock_tracker.sv
// ----------------------------------------------------------------------------
// Server clock tracker
// Turns local frame time into the client's view of remote time, keeping an
// offset that follows incoming snapshot times.
//
//   Channel   Ports                                   Direction
//   req       req_valid, req_stall, req_* fields      in, one frame tick a beat
//   rsp       rsp_valid, rsp_stall, rsp_* fields      out, one result a beat
//   csr       csr_wr_en, csr_index, csr_wdata         in, write only
//
// A beat is taken into an input register, worked out against the tracker
// state and placed in the result register, one beat a cycle sustained while
// the result is not stalled. The state update closes through the state
// register alone, so consecutive beats never wait on each other.
// Reset is synchronous; it empties both registers and restores all state
// and register defaults. A stalled result holds the input register, which
// then stalls the request side.
// ----------------------------------------------------------------------------
`default_nettype none

module server_clock_tracker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [30:0]                   req_local_time,
   input  wire logic [30:0]                   req_snap_time,
   input  wire logic                          req_new_snapshot,
   input  wire logic                          req_snap_inactive,
   input  wire logic                          req_paused,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [30:0]                        rsp_view_time,
   output logic                               rsp_is_active,
   output logic [2:0]                         rsp_adjust_mode,
   output logic                               rsp_resynced,
   input  wire logic                          csr_wr_en,
   input  wire logic [sct_pkg::IDX_BITS-1:0]  csr_index,
   input  wire logic [sct_pkg::CSR_BITS-1:0]  csr_wdata
);

   sct_pkg::cfg_type    cfg;
   sct_pkg::item_type   item_ff;
   sct_pkg::item_type   item_in;
   logic                in_valid_ff;
   logic                in_valid_in;
   sct_pkg::state_type  state_ff;
   sct_pkg::state_type  state_in;
   sct_pkg::result_type res_ff;
   sct_pkg::result_type res_in;
   logic                out_valid_ff;
   logic                out_valid_in;
   logic                advance;
   logic                req_take;

   sct_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sct_step u_step (
      .state      (state_ff),
      .item       (item_ff),
      .cfg        (cfg),
      .state_next (state_in),
      .result     (res_in)
   );

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      item_in.local_time    = req_local_time;
      item_in.snap_time     = req_snap_time;
      item_in.new_snapshot  = req_new_snapshot;
      item_in.snap_inactive = req_snap_inactive;
      item_in.paused        = req_paused;
      in_valid_in  = req_take || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= item_in;
      end
      if (advance) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_view_time   = res_ff.view_time;
   assign rsp_is_active   = res_ff.is_active;
   assign rsp_adjust_mode = res_ff.adjust_mode;
   assign rsp_resynced    = res_ff.resynced;

`ifndef SYNTHESIS
   a_active_sticks: assert property (@(posedge clock) disable iff (reset)
      state_ff.active |=> state_ff.active)
      else $error("tracker left the active state without reset");

   a_resync_active: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_resynced || rsp_adjust_mode != sct_pkg::ADJ_NONE))
         |-> rsp_is_active)
      else $error("adjustment reported while not active");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall))
      else $error("request stalled with room to take the beat");

   a_beat_kept: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(item_ff)))
      else $error("held beat lost from the input register");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/sct_csr.sv
// ----------------------------------------------------------------------------
// Server clock tracker control registers
// Holds the thresholds, nudge, drift enable and edge margin written by the
// write-only register port.
// ----------------------------------------------------------------------------
`default_nettype none

module sct_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_wr_en,
   input  wire logic [sct_pkg::IDX_BITS-1:0]     csr_index,
   input  wire logic [sct_pkg::CSR_BITS-1:0]     csr_wdata,
   output sct_pkg::cfg_type                      cfg
);

   sct_pkg::cfg_type cfg_ff;
   sct_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            sct_pkg::CSR_RESET_THR:   cfg_in.reset_threshold   = csr_wdata;
            sct_pkg::CSR_FAST_THR:    cfg_in.fast_threshold    = csr_wdata;
            sct_pkg::CSR_TIME_NUDGE:  cfg_in.time_nudge        = csr_wdata[7:0];
            sct_pkg::CSR_FINE_DRIFT:  cfg_in.fine_drift_enable = csr_wdata[0];
            sct_pkg::CSR_EDGE_MARGIN: cfg_in.edge_margin       = csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_threshold   <= 16'd500;
         cfg_ff.fast_threshold    <= 16'd100;
         cfg_ff.time_nudge        <= 8'sd0;
         cfg_ff.fine_drift_enable <= 1'b1;
         cfg_ff.edge_margin       <= 8'd5;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> hw/rtl/sct_step.sv
// ----------------------------------------------------------------------------
// Server clock tracker step logic
// Works out the next tracker state and the result for one frame tick.
// ----------------------------------------------------------------------------
`default_nettype none

module sct_step (
   input  wire sct_pkg::state_type  state,
   input  wire sct_pkg::item_type   item,
   input  wire sct_pkg::cfg_type    cfg,
   output sct_pkg::state_type       state_next,
   output sct_pkg::result_type      result
);

   always_comb begin
      sct_pkg::state_type  st;
      sct_pkg::time_type   local_t;
      sct_pkg::time_type   snap_t;
      sct_pkg::time_type   base;
      sct_pkg::time_type   view;
      sct_pkg::time_type   target;
      sct_pkg::time_type   err;
      sct_pkg::time_type   sum;
      logic [7:0]          nudge_mag;
      logic                nudge_neg;
      logic                snap_seen;
      sct_pkg::adjust_type mode;
      logic                resync;

      st        = state;
      local_t   = sct_pkg::time_type'(item.local_time);
      snap_t    = sct_pkg::time_type'(item.snap_time);
      snap_seen = item.new_snapshot | state.pending;
      st.pending = 1'b0;
      mode      = sct_pkg::ADJ_NONE;
      resync    = 1'b0;
      base      = '0;
      view      = '0;
      target    = '0;
      err       = '0;
      sum       = '0;

      nudge_neg = cfg.time_nudge[7];
      nudge_mag = nudge_neg ? 8'(-cfg.time_nudge) : cfg.time_nudge;
      if (nudge_mag > sct_pkg::NUDGE_MAX) begin
         nudge_mag = sct_pkg::NUDGE_MAX;
      end

      if (!st.active && snap_seen) begin
         snap_seen = 1'b0;
         if (!item.snap_inactive) begin
            st.active    = 1'b1;
            st.offset    = snap_t - local_t;
            st.last_view = snap_t;
         end
      end

      if (st.active && item.paused) begin
         st.pending = snap_seen;
      end else if (st.active) begin
         if (sct_pkg::time_less(snap_t, st.last_frame_snap) && !item.snap_inactive) begin
            st.offset    = snap_t - local_t;
            st.last_view = snap_t;
            resync       = 1'b1;
         end
         st.last_frame_snap = snap_t;

         base = local_t + st.offset;
         view = nudge_neg ? base + sct_pkg::time_type'(nudge_mag)
                          : base - sct_pkg::time_type'(nudge_mag);
         if (sct_pkg::time_less(view, st.last_view)) begin
            view = st.last_view;
         end
         st.last_view = view;
         st.view_reg  = view;

         if (!sct_pkg::time_less(base, snap_t - sct_pkg::time_type'(cfg.edge_margin))) begin
            st.extrapolated = 1'b1;
         end

         if (snap_seen) begin
            target = snap_t - local_t;
            err    = sct_pkg::time_abs(target - st.offset);
            sum    = st.offset + target;
            if (err > sct_pkg::time_type'(cfg.reset_threshold)) begin
               st.offset    = target;
               st.last_view = snap_t;
               st.view_reg  = snap_t;
               mode         = sct_pkg::ADJ_RESET;
            end else if (err > sct_pkg::time_type'(cfg.fast_threshold)) begin
               st.offset = {sum[sct_pkg::TIME_BITS-1], sum[sct_pkg::TIME_BITS-1:1]};
               mode      = sct_pkg::ADJ_FAST;
            end else if (cfg.fine_drift_enable) begin
               if (st.extrapolated) begin
                  st.extrapolated = 1'b0;
                  st.offset       = st.offset - sct_pkg::time_type'(2);
                  mode            = sct_pkg::ADJ_BACK;
               end else begin
                  st.offset = st.offset + sct_pkg::time_type'(1);
                  mode      = sct_pkg::ADJ_FWD;
               end
            end
         end
      end

      state_next         = st;
      result.view_time   = sct_pkg::ms_type'(st.view_reg);
      result.is_active   = st.active;
      result.adjust_mode = mode;
      result.resynced    = resync;
   end

endmodule

`default_nettype wire
